>>> rtl/tcw_pkg.sv
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

  localparam int TCW_COLUMNS      = 80;
  localparam int TCW_ROWS         = 25;
  localparam int TCW_CMD_DEPTH    = 4;
  localparam int TCW_RES_DEPTH    = 2;

  localparam int POS_W            = 11;
  localparam int CELL_W           = 16;
  localparam int CFG_DATA_W       = 32;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [7:0]        CHAR_NEWLINE    = 8'd10;
  localparam logic [7:0]        CHAR_SPACE      = 8'h20;
  localparam logic [7:0]        RESET_ATTRIBUTE = 8'h1F;
  localparam logic [CELL_W-1:0] RESET_CELL      = 16'h1F20;

  // register index (paddr above the byte offset)
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_PUT     = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [POS_W-1:0]  cursor_position;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } cmd_t;

endpackage

>>> rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tcw_queue.sv
// Small register queue; DEPTH must be a power of two.
module tcw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/tcw_front.sv
// Input side: takes words and turns each into a command for the back end.
module tcw_front import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = TCW_COLUMNS,
  parameter int SCREEN_ROWS    = TCW_ROWS
) (
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  input  logic     cq_full,
  input  logic     init_busy,
  output logic     cq_push,
  output cmd_t     cq_data
);

  logic read_in_range;

  assign in_full = cq_full | init_busy;
  assign cq_push = in_push & ~in_full;

  assign read_in_range = (32'(in_item.read_row) < 32'(SCREEN_ROWS)) &&
                         (32'(in_item.read_column) < 32'(SCREEN_COLUMNS));

  always_comb begin
    cq_data.char_code   = in_item.char_code;
    cq_data.read_row    = in_item.read_row;
    cq_data.read_column = in_item.read_column;
    case (in_item.func)
      FUNC_PUT: begin
        cq_data.op = (in_item.char_code == CHAR_NEWLINE) ? OP_NEWLINE : OP_PUT;
      end
      FUNC_CLEAR: begin
        cq_data.op = OP_CLEAR;
      end
      FUNC_READ: begin
        // off-screen reads return zero and touch nothing
        cq_data.op = read_in_range ? OP_READ : OP_NOP;
      end
      default: begin
        cq_data.op = OP_NOP;
      end
    endcase
  end

endmodule

>>> rtl/tcw_back.sv
// Back end: cursor, screen RAM sequencing for the reset sweep, writes, reads, scroll and clear.
module tcw_back import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = TCW_COLUMNS,
  parameter int SCREEN_ROWS    = TCW_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [7:0] attr,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  logic      oq_full,
  output logic      oq_push,
  output out_item_t oq_data,
  output logic      init_busy
);

  localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - SCREEN_COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_BLANK  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] lin_r, lin_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              wr_pend_r, wr_pend_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic [31:0]       rd_lin;
  logic [CELL_W-1:0] blank_cell;
  logic [POS_W+ADDR_W-1:0] pos_ext;

  assign blank_cell = {attr, CHAR_SPACE};
  assign rd_lin     = 32'(cmd.read_row) * 32'(SCREEN_COLUMNS) + 32'(cmd.read_column);
  assign pos_ext    = {{POS_W{1'b0}}, lin_nxt};
  assign init_busy  = (state_r == S_INIT);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    lin_nxt     = lin_r;
    scan_nxt    = scan_r;
    wr_addr_nxt = wr_addr_r;
    wr_pend_nxt = wr_pend_r;
    ram_we      = 1'b0;
    ram_waddr   = scan_r;
    ram_wdata   = blank_cell;
    ram_raddr   = rd_lin[ADDR_W-1:0];
    cmd_pop     = 1'b0;
    oq_push     = 1'b0;
    oq_data.cell_value      = '0;
    oq_data.cursor_position = pos_ext[POS_W-1:0];

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        scan_nxt  = scan_r + 1'b1;
        if (scan_r == CELL_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // popping only with room in the result queue guarantees the later push
        if (cmd_valid && !oq_full) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = lin_r;
              ram_wdata = {attr, cmd.char_code};
              if (col_r == COL_LAST) begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  lin_nxt     = LAST_BASE;
                  scan_nxt    = '0;
                  wr_pend_nxt = 1'b0;
                  state_nxt   = S_SCROLL;
                end else begin
                  row_nxt = row_r + 1'b1;
                  lin_nxt = lin_r + 1'b1;
                  oq_push = 1'b1;
                end
              end else begin
                col_nxt = col_r + 1'b1;
                lin_nxt = lin_r + 1'b1;
                oq_push = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_nxt = '0;
              if (row_r == ROW_LAST) begin
                lin_nxt     = LAST_BASE;
                scan_nxt    = '0;
                wr_pend_nxt = 1'b0;
                state_nxt   = S_SCROLL;
              end else begin
                row_nxt = row_r + 1'b1;
                lin_nxt = lin_r + COLS_A - ADDR_W'(col_r);
                oq_push = 1'b1;
              end
            end
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              lin_nxt   = '0;
              scan_nxt  = '0;
              state_nxt = S_BLANK;
            end
            OP_READ: begin
              state_nxt = S_READ;
            end
            default: begin
              oq_push = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        oq_push            = 1'b1;
        oq_data.cell_value = ram_rdata;
        state_nxt          = S_IDLE;
      end

      S_SCROLL: begin
        // read one row below, write it back the next cycle
        ram_raddr   = scan_r + COLS_A;
        ram_we      = wr_pend_r;
        ram_waddr   = wr_addr_r;
        ram_wdata   = ram_rdata;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = scan_r;
        if (scan_r == COPY_LAST) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_DRAIN: begin
        ram_we      = 1'b1;
        ram_waddr   = wr_addr_r;
        ram_wdata   = ram_rdata;
        wr_pend_nxt = 1'b0;
        scan_nxt    = LAST_BASE;
        state_nxt   = S_BLANK;
      end

      S_BLANK: begin
        ram_we = 1'b1;
        if (scan_r == CELL_LAST) begin
          oq_push   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      col_r     <= '0;
      row_r     <= '0;
      lin_r     <= '0;
      scan_r    <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      lin_r     <= lin_nxt;
      scan_r    <= scan_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full)
    else $error("result pushed into a full queue");

  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (cmd_valid && !oq_full))
    else $error("command taken without result room");

  a_cursor_linear: assert property (@(posedge clk) disable iff (!rst_n)
    32'(lin_r) == 32'(row_r) * 32'(SCREEN_COLUMNS) + 32'(col_r))
    else $error("linear cursor out of step with row and column");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(SCREEN_ROWS)) && (32'(col_r) < 32'(SCREEN_COLUMNS)))
    else $error("cursor off screen");

  a_scroll_copy_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL && wr_pend_r) |-> (wr_addr_r == scan_r - 1'b1))
    else $error("scroll write trails read by more than one cell");

endmodule

>>> rtl/text_console_writer_core.sv
// Text console writer: a screen of character cells fed from a command queue.
//
// Input channel: a word (func, char_code, read_row, read_column) is taken on a
// clock edge with in_push high and in_full low. func 0 writes a character at
// the cursor (10 is newline), 1 clears the screen, 2 reads one cell.
// Result channel: every input word gives one result word (cell_value,
// cursor_position), shown while out_empty is low and taken with out_pop.
// Configuration: APB-style port, text_attribute at byte address 0.
// Timing: a front end classifies words into a 4-deep command queue; a back
// end executes one command at a time against a single-port-write screen RAM.
// A character or newline is executed in S_IDLE and its result is registered in
// the result queue; one character per cycle is sustained while no read, scroll
// or clear is under way and the result queue has room. A read passes through
// S_READ, as the RAM read data are registered. A scroll copies all rows but the
// first at one cell per cycle and then blanks the bottom row; a clear blanks every cell.
// Reset: a sweep writes 0x1F20 to every cell, with in_full held high;
// configuration writes are taken throughout.
// A stalled receiver fills the 2-deep result queue, after which the back end
// stops and the command queue fills, raising in_full.
module text_console_writer_core import tcw_pkg::*; #(
  parameter int SCREEN_COLUMNS = TCW_COLUMNS,
  parameter int SCREEN_ROWS    = TCW_ROWS,
  parameter int CMD_DEPTH      = TCW_CMD_DEPTH,
  parameter int RES_DEPTH      = TCW_RES_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  in_item_t              in_item,
  output logic                  in_full,
  input  logic                  out_pop,
  output out_item_t             out_item,
  output logic                  out_empty,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [7:0] attr_r, attr_nxt;
  logic       cfg_hit;

  logic       cq_push, cq_full, cq_empty, cmd_pop, init_busy;
  cmd_t       cq_wdata;
  logic [$bits(cmd_t)-1:0] cq_rdata;

  logic       oq_push, oq_full;
  out_item_t  oq_wdata;
  logic [$bits(out_item_t)-1:0] oq_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_TEXT_ATTRIBUTE);
  assign cfg_prdata = cfg_hit ? {{(CFG_DATA_W - 8){1'b0}}, attr_r} : '0;

  always_comb begin
    attr_nxt = attr_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      attr_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTRIBUTE;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  tcw_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cq_full   (cq_full),
    .init_busy (init_busy),
    .cq_push   (cq_push),
    .cq_data   (cq_wdata)
  );

  tcw_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cmd_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  tcw_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr_r),
    .cmd       (cmd_t'(cq_rdata)),
    .cmd_valid (~cq_empty),
    .cmd_pop   (cmd_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_data   (oq_wdata),
    .init_busy (init_busy)
  );

  tcw_queue #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty)
  );

  assign out_item = out_item_t'(oq_rdata);

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the text console writer: predictor, queue handshakes, APB config.
module testbench;
  import tcw_pkg::*;

  localparam int CELLS           = TCW_COLUMNS * TCW_ROWS;
  localparam int ITEMS_PER_CHUNK = 280;
  localparam int NUM_CHUNKS      = 6;
  localparam int LONG_STALL      = 400;
  // time for a scroll or clear to finish; leave room for a trailing stray word
  localparam int SETTLE_CYCLES   = CELLS + 100;
  localparam int CYCLE_LIMIT     = 3_000_000;

  localparam logic [1:0] FUNC_UNUSED     = 2'd3;
  localparam logic       REG_BEYOND_LIST = 1'b1;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  func;
    logic [7:0]  chr;
    logic [4:0]  rrow;
    logic [6:0]  rcol;
    logic        reg_idx;
    logic [7:0]  reg_val;
    logic        typed;
    logic [15:0] want_cell;
    logic [10:0] want_pos;
  } dir_row_t;

  localparam int N_DIRECTED = 25;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd0,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h1F20, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd31, 7'd127, REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd25, 7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd0,  7'd80,  REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_UNUSED, 8'hFF, 5'd31, 7'd127, REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_PUT,    8'h41, 5'd31, 7'd127, REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h0000, 11'd1},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd0,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h1F41, 11'd1},
    '{ROW_WORD, FUNC_PUT,    8'h00, 5'd0,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b0, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_PUT,    8'hFF, 5'd0,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b0, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd0,  7'd2,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h1FFF, 11'd3},
    '{ROW_REG,  FUNC_PUT,    8'h00, 5'd0,  7'd0,   REG_TEXT_ATTRIBUTE, 8'hFF, 1'b0, 16'h0000, 11'd0},
    '{ROW_REG,  FUNC_PUT,    8'h00, 5'd0,  7'd0,   REG_BEYOND_LIST,    8'h00, 1'b0, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd24, 7'd79,  REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h1F20, 11'd3},
    '{ROW_WORD, FUNC_PUT,    CHAR_NEWLINE, 5'd0, 7'd0, REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h0000, 11'd80},
    '{ROW_WORD, FUNC_PUT,    8'h80, 5'd0,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b0, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd1,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'hFF80, 11'd81},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd1,  7'd1,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b0, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_CLEAR,  CHAR_NEWLINE, 5'd24, 7'd79, REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h0, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd1,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'hFF20, 11'd0},
    '{ROW_REG,  FUNC_PUT,    8'h00, 5'd0,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b0, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_PUT,    CHAR_SPACE, 5'd0, 7'd0, REG_TEXT_ATTRIBUTE, 8'h00, 1'b0, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd0,  7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'h0020, 11'd1},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd0,  7'd79,  REG_TEXT_ATTRIBUTE, 8'h00, 1'b0, 16'h0000, 11'd0},
    '{ROW_WORD, FUNC_PUT,    CHAR_NEWLINE, 5'd0, 7'd0, REG_TEXT_ATTRIBUTE, 8'h00, 1'b0, 16'h0, 11'd0},
    '{ROW_WORD, FUNC_READ,   8'h00, 5'd24, 7'd0,   REG_TEXT_ATTRIBUTE, 8'h00, 1'b1, 16'hFF20, 11'd80}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  in_item_t              in_item;
  logic                  in_full;
  logic                  out_pop;
  out_item_t             out_item;
  logic                  out_empty;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // shadow of the console
  logic [CELL_W-1:0] screen_mem [CELLS];
  int                cur_col;
  int                cur_row;
  logic [7:0]        attr_reg;

  out_item_t expected_words [$];
  int        error_count = 0;
  int        words_sent = 0;
  int        words_checked = 0;
  int        scrolls_seen = 0;
  int        clears_seen = 0;
  int        line_left = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_requests = 0;
  int        cycle_count = 0;

  text_console_writer_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_item     (in_item),
    .in_full     (in_full),
    .out_pop     (out_pop),
    .out_item    (out_item),
    .out_empty   (out_empty),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [CELL_W-1:0] attr_cell(logic [7:0] ch);
    return {attr_reg, ch};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - TCW_COLUMNS; i++) screen_mem[i] = screen_mem[i + TCW_COLUMNS];
    for (int i = CELLS - TCW_COLUMNS; i < CELLS; i++) screen_mem[i] = attr_cell(CHAR_SPACE);
    cur_row = TCW_ROWS - 1;
    scrolls_seen++;
  endfunction

  function automatic out_item_t console_predict(in_item_t w);
    out_item_t res;
    res = '0;
    case (w.func)
      FUNC_PUT: begin
        if (w.char_code == CHAR_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen_mem[cur_row * TCW_COLUMNS + cur_col] = attr_cell(w.char_code);
          cur_col++;
          if (cur_col >= TCW_COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= TCW_ROWS) scroll_screen();
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_mem[i] = attr_cell(CHAR_SPACE);
        cur_col = 0;
        cur_row = 0;
        clears_seen++;
      end
      FUNC_READ: begin
        if (int'(w.read_row) < TCW_ROWS && int'(w.read_column) < TCW_COLUMNS)
          res.cell_value = screen_mem[int'(w.read_row) * TCW_COLUMNS + int'(w.read_column)];
      end
      default: ;
    endcase
    res.cursor_position = POS_W'(cur_row * TCW_COLUMNS + cur_col);
    return res;
  endfunction

  // text is mostly short lines so the cursor reaches the bottom and scrolls often
  function automatic in_item_t next_console_word();
    in_item_t w;
    int       pick;
    int       sel;
    w.func        = FUNC_PUT;
    w.char_code   = 8'($urandom_range(255));
    w.read_row    = 5'($urandom_range(31));
    w.read_column = 7'($urandom_range(127));
    pick = $urandom_range(999);
    if (pick < 4) begin
      w.func = FUNC_CLEAR;
    end else if (pick < 16) begin
      w.func = FUNC_UNUSED;
    end else if (pick < 166) begin
      w.func = FUNC_READ;
      sel = $urandom_range(9);
      if (sel < 5) begin
        w.read_row    = 5'((cur_row > 0) ? cur_row - int'($urandom_range(1)) : 0);
        w.read_column = 7'($urandom_range(TCW_COLUMNS - 1));
      end else if (sel < 8) begin
        w.read_row    = 5'($urandom_range(TCW_ROWS - 1));
        w.read_column = 7'($urandom_range(TCW_COLUMNS - 1));
      end
    end else if (line_left == 0) begin
      w.char_code = CHAR_NEWLINE;
      line_left = ($urandom_range(19) == 0) ? int'($urandom_range(170, 80))
                                             : int'($urandom_range(8));
    end else begin
      line_left--;
    end
    return w;
  endfunction

  // called at a clock edge; returns at the edge that takes the word
  task automatic push_word(input in_item_t w, input bit typed, input out_item_t typed_val);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (in_full !== 1'b0);
    predicted = console_predict(w);
    expected_words.push_back(typed ? typed_val : predicted);
    words_sent++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_TEXT_ATTRIBUTE) attr_reg = value;
    @(posedge clk);
  endtask

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_count, expected_words.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : result_sink
    out_item_t want;
    int        hold_left;
    int        stalls_served;
    hold_left     = 0;
    stalls_served = 0;
    out_pop       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_pop && out_empty === 1'b0) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word cell=%h pos=%0d", $time,
                   out_item.cell_value, out_item.cursor_position);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (out_item.cell_value !== want.cell_value) begin
            $display("%0t: cell_value expected %h got %h", $time,
                     want.cell_value, out_item.cell_value);
            error_count++;
          end
          if (out_item.cursor_position !== want.cursor_position) begin
            $display("%0t: cursor_position expected %0d got %0d", $time,
                     want.cursor_position, out_item.cursor_position);
            error_count++;
          end
        end
      end
      if (stalls_served != stall_requests) begin
        stalls_served = stall_requests;
        hold_left     = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    dir_row_t   row;
    in_item_t   word;
    logic [7:0] attr_val;
    logic [7:0] chunk_attr [NUM_CHUNKS];
    chunk_attr  = '{8'hFF, 8'h00, 8'h5A, 8'h00, 8'h80, 8'hFF};
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_item     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    for (int i = 0; i < CELLS; i++) screen_mem[i] = RESET_CELL;
    cur_col  = 0;
    cur_row  = 0;
    attr_reg = RESET_ATTRIBUTE;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 86;

    for (int n = 0; n < N_DIRECTED; n++) begin
      row = DIRECTED[n];
      if (row.kind == ROW_REG) begin
        drain();
        write_register(row.reg_idx, row.reg_val);
      end else begin
        word.func        = row.func;
        word.char_code   = row.chr;
        word.read_row    = row.rrow;
        word.read_column = row.rcol;
        push_word(word, row.typed, {row.want_cell, row.want_pos});
      end
    end

    for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      if (chunk < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 86;
      end else if (chunk < 4) begin
        send_idle_pct = 86;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      attr_val = (chunk == 3) ? 8'($urandom_range(255)) : chunk_attr[chunk];
      drain();
      write_register(REG_TEXT_ATTRIBUTE, attr_val);
      for (int i = 0; i < ITEMS_PER_CHUNK; i++) begin
        // long receiver stall lets both queues fill and in_full rise
        if ((chunk == 2 || chunk == 4) && i == 100) stall_requests++;
        if (chunk == 1 && i == 140) drain();
        push_word(next_console_word(), 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d words, checked %0d results over %0d cycles", words_sent,
             words_checked, cycle_count);
    $display("predicted %0d scrolls and %0d clears", scrolls_seen, clears_seen);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
